[hw/rtl/csvft_pkg.sv]
// ----------------------------------------------------------------------------
// csvft_pkg
// Shared types and constants of the CSV field tokenizer.
// ----------------------------------------------------------------------------
package csvft_pkg;

    localparam logic [7:0] CH_CR         = 8'd13;
    localparam logic [7:0] CH_LF         = 8'd10;
    localparam logic [7:0] SEP_RESET     = 8'd44;
    localparam logic [7:0] QUOTE_RESET   = 8'd34;
    localparam logic [7:0] CFG_IDX_SEP   = 8'd0;
    localparam logic [7:0] CFG_IDX_QUOTE = 8'd1;

    typedef enum logic [1:0] {
        TK_CHAR    = 2'd0,
        TK_RESTART = 2'd1,
        TK_FIELD   = 2'd2,
        TK_RECORD  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        QM_OUT   = 2'd0,
        QM_IN    = 2'd1,
        QM_QSEEN = 2'd2
    } t_qmode;

    // One classified byte: first token, plus an optional record end after it
    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic       two;
    } t_entry;

endpackage

[hw/rtl/csvft_front.sv]
// ----------------------------------------------------------------------------
// csvft_front
// Accepts bytes, tracks quoting state and classifies each byte into at most one entry.
// ----------------------------------------------------------------------------
module csvft_front
    import csvft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_final_byte,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output logic       o_push,
    output t_entry     o_entry
);

    logic [7:0] r_sep;
    logic [7:0] r_quote;
    t_qmode     r_mode;
    t_qmode     n_mode;
    logic       r_drop;
    logic       n_drop;

    logic       swallow;
    logic       rec_end;
    logic       have_first;
    t_kind      first_kind;
    logic [7:0] first_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep   <= SEP_RESET;
            r_quote <= QUOTE_RESET;
            r_mode  <= QM_OUT;
            r_drop  <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_IDX_SEP) begin
                r_sep <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_IDX_QUOTE) begin
                r_quote <= i_cfg_data;
            end
            if (i_accept) begin
                r_mode <= n_mode;
                r_drop <= n_drop;
            end
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_drop     = r_drop;
        swallow    = 1'b0;
        rec_end    = 1'b0;
        have_first = 1'b0;
        first_kind = TK_CHAR;
        first_ch   = 8'd0;

        if (r_drop) begin
            n_drop  = 1'b0;
            swallow = (i_in_byte == CH_LF);
        end

        if (!swallow) begin
            case (r_mode)
                QM_IN: begin
                    if (i_in_byte == r_quote) begin
                        n_mode = QM_QSEEN;
                    end else begin
                        have_first = 1'b1;
                        first_ch   = i_in_byte;
                    end
                end
                QM_QSEEN: begin
                    if (i_in_byte == r_quote) begin
                        have_first = 1'b1;
                        first_ch   = r_quote;
                        n_mode     = QM_IN;
                    end else if (i_in_byte == r_sep) begin
                        have_first = 1'b1;
                        first_kind = TK_FIELD;
                        n_mode     = QM_OUT;
                    end else if (i_in_byte == CH_CR || i_in_byte == CH_LF) begin
                        rec_end = 1'b1;
                        n_drop  = (i_in_byte == CH_CR);
                    end
                end
                default: begin
                    if (i_in_byte == r_sep) begin
                        have_first = 1'b1;
                        first_kind = TK_FIELD;
                    end else if (i_in_byte == r_quote) begin
                        have_first = 1'b1;
                        first_kind = TK_RESTART;
                        n_mode     = QM_IN;
                    end else if (i_in_byte == CH_CR || i_in_byte == CH_LF) begin
                        rec_end = 1'b1;
                        n_drop  = (i_in_byte == CH_CR);
                    end else begin
                        have_first = 1'b1;
                        first_ch   = i_in_byte;
                    end
                end
            endcase
        end

        if (rec_end) begin
            n_mode = QM_OUT;
        end
        if (i_final_byte) begin
            n_mode = QM_OUT;
            n_drop = 1'b0;
        end

        o_entry = '0;
        o_push  = 1'b0;
        if (have_first) begin
            o_entry.kind = first_kind;
            o_entry.ch   = first_ch;
            o_entry.two  = rec_end || (i_final_byte && !swallow);
            o_push       = i_accept;
        end else if (rec_end || (i_final_byte && !swallow)) begin
            o_entry.kind = TK_RECORD;
            o_push       = i_accept;
        end
    end

endmodule

[hw/rtl/csvft_queue.sv]
// ----------------------------------------------------------------------------
// csvft_queue
// Small FIFO of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module csvft_queue
    import csvft_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_head,
    output logic   o_valid,
    output logic   o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head  = r_mem[r_rptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == FULL_CNT);

endmodule

[hw/rtl/csvft_back.sv]
// ----------------------------------------------------------------------------
// csvft_back
// Output register; expands each entry into one or two result beats.
// ----------------------------------------------------------------------------
module csvft_back
    import csvft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_head,
    input  logic       i_q_valid,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [1:0] o_token_kind,
    output logic [7:0] o_value_char,
    output logic       o_run_last
);

    logic   r_valid;
    logic   r_second;
    t_entry r_ent;
    logic   last;
    logic   load;

    assign last    = r_second || !r_ent.two;
    assign load    = !r_valid || (i_pop && last);
    assign o_q_pop = load && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid  <= i_q_valid;
            r_second <= 1'b0;
        end else if (i_pop) begin
            r_second <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ent <= i_head;
        end
    end

    assign o_empty      = !r_valid;
    assign o_token_kind = r_second ? TK_RECORD : r_ent.kind;
    assign o_value_char = r_second ? 8'd0 : r_ent.ch;
    assign o_run_last   = last;

endmodule

[hw/rtl/csv_field_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// csv_field_tokenizer_top
// Byte-serial CSV tokenizer: quote tracking front, entry FIFO, result back.
// ----------------------------------------------------------------------------
// Path: the first result of a byte is written to the entry FIFO, then loaded into the output register.
// Throughput: one byte per cycle while the entry FIFO is not full; a byte with two results
// occupies the output register for both its beats, the entry FIFO of QDEPTH entries absorbs the burst.
// Reset: synchronous, active low; clears quoting state, FIFO and output,
// loads separator ',' and quote '"'.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_top
    import csvft_pkg::*;
#(
    parameter int QDEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_final_byte,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_token_kind,
    output logic [7:0] o_value_char,
    output logic       o_run_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic   accept;
    logic   f_push;
    t_entry f_entry;
    t_entry q_head;
    logic   q_valid;
    logic   q_pop;

    assign accept      = push && !full;
    assign o_cfg_ready = 1'b1;

    csvft_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_in_byte    (i_in_byte),
        .i_final_byte (i_final_byte),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_push       (f_push),
        .o_entry      (f_entry)
    );

    csvft_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_entry (f_entry),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_valid (q_valid),
        .o_full  (full)
    );

    csvft_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_q_valid    (q_valid),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_token_kind (o_token_kind),
        .o_value_char (o_value_char),
        .o_run_last   (o_run_last)
    );

    // a beat that is not the last of its byte is never a record end
    a_nonlast_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_run_last |-> o_token_kind != TK_RECORD)
        else $error("non-last beat carries record end");

    // the beat after a non-last one is the record end of the same byte
    a_second_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && !o_run_last |=>
            !empty && o_run_last && o_token_kind == TK_RECORD)
        else $error("missing record end after first beat");

    // only character beats carry a value
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_token_kind != TK_CHAR |-> o_value_char == 8'd0)
        else $error("value on non-character beat");

    // an empty output register always takes the FIFO head at once
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        empty && q_valid |-> q_pop)
        else $error("output register idle while FIFO holds entries");

endmodule
